/* rtl/edge_spacing_check_core_macros.svh */
// Assertion macros for the edge spacing check core.
// Included by the controller and datapath; needs no package.
`ifndef EDGE_SPACING_CHECK_CORE_MACROS_SVH
`define EDGE_SPACING_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ESC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge spacing check: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge spacing check: assertion failed");

`endif

/* rtl/esc_pkg.sv */
// Shared types and constants for the edge spacing check core.
// Used by esc_ctrl, esc_dpath and edge_spacing_check_core; no dependencies.
`timescale 1ns / 1ps

package esc_pkg;

    localparam int EDGE_DEPTH_DEFAULT = 64;
    localparam int COORD_W            = 32;
    localparam int SPACING_W          = 31;
    localparam int CMD_W              = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CHECK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic advance;
        logic emit;
        logic emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic done;
        logic pend_valid;
        logic out_free;
    } dp_sts_t;

endpackage

/* rtl/esc_ctrl.sv */
// Controller for the edge spacing check: command decode and scan sequencing.
// Depends on esc_pkg and edge_spacing_check_core_macros.svh.
`timescale 1ns / 1ps
`include "edge_spacing_check_core_macros.svh"

module esc_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [esc_pkg::CMD_W-1:0]         s_command,
    input  esc_pkg::dp_sts_t                  sts,
    output esc_pkg::dp_cmd_t                  cmd
);

    esc_pkg::state_t state_reg;
    esc_pkg::state_t state_next;
    logic            busy_to_idle;
    logic            scan_done;
    logic            in_flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= esc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            esc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (esc_pkg::cmd_t'(s_command))
                        esc_pkg::CMD_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        esc_pkg::CMD_APPEND: begin
                            cmd.append = 1'b1;
                        end
                        esc_pkg::CMD_CHECK: begin
                            cmd.start  = 1'b1;
                            state_next = esc_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            esc_pkg::ST_SCAN: begin
                if (sts.done) begin
                    state_next = esc_pkg::ST_FLUSH;
                end else if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
                    cmd.advance = 1'b1;
                    cmd.emit    = sts.hit && sts.pend_valid;
                end
            end
            esc_pkg::ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = esc_pkg::ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = esc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = esc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy_to_idle = (state_reg != esc_pkg::ST_IDLE) && (state_next == esc_pkg::ST_IDLE);
    assign scan_done    = (state_reg == esc_pkg::ST_SCAN) && sts.done;
    assign in_flush     = (state_reg == esc_pkg::ST_FLUSH);

    `ESC_ASSERT_NEXT(a_idle_no_pending, aclk, aresetn, busy_to_idle, !sts.pend_valid)
    `ESC_ASSERT_NEXT(a_done_to_flush, aclk, aresetn, scan_done, in_flush)
    `ESC_ASSERT_IMPLY(a_last_only_flush, aclk, aresetn, cmd.emit_last, in_flush && !cmd.advance)

endmodule

/* rtl/esc_dpath.sv */
// Datapath for the edge spacing check: edge store, scan index, pair test,
// pending violation and result register. Depends on esc_pkg and the macros header.
`timescale 1ns / 1ps
`include "edge_spacing_check_core_macros.svh"

module esc_dpath #(
    parameter int EDGE_DEPTH = esc_pkg::EDGE_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [esc_pkg::SPACING_W-1:0]        cfg_wr_data,
    input  logic signed [esc_pkg::COORD_W-1:0]   s_edge_position,
    input  logic signed [esc_pkg::COORD_W-1:0]   s_span_from,
    input  logic signed [esc_pkg::COORD_W-1:0]   s_span_to,
    input  esc_pkg::dp_cmd_t                     cmd,
    output esc_pkg::dp_sts_t                     sts,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [esc_pkg::COORD_W-1:0]   m_first_position,
    output logic signed [esc_pkg::COORD_W-1:0]   m_first_from,
    output logic signed [esc_pkg::COORD_W-1:0]   m_first_to,
    output logic signed [esc_pkg::COORD_W-1:0]   m_second_position,
    output logic signed [esc_pkg::COORD_W-1:0]   m_second_from,
    output logic signed [esc_pkg::COORD_W-1:0]   m_second_to,
    output logic                                 m_last_of_run
);

    localparam int AW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int CW = $clog2(EDGE_DEPTH + 1);
    localparam int DW = esc_pkg::COORD_W + 1;

    logic signed [esc_pkg::COORD_W-1:0] mem_pos  [EDGE_DEPTH];
    logic signed [esc_pkg::COORD_W-1:0] mem_from [EDGE_DEPTH];
    logic signed [esc_pkg::COORD_W-1:0] mem_to   [EDGE_DEPTH];

    logic [esc_pkg::SPACING_W-1:0]      ms_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      idx_reg;
    logic [CW-1:0]                      addr_sel;
    logic                               full;

    logic signed [esc_pkg::COORD_W-1:0] chk_pos_reg, chk_from_reg, chk_to_reg;
    logic signed [esc_pkg::COORD_W-1:0] rd_pos_reg, rd_from_reg, rd_to_reg;
    logic signed [esc_pkg::COORD_W-1:0] pend_pos_reg, pend_from_reg, pend_to_reg;
    logic                               pend_valid_reg;

    logic signed [esc_pkg::COORD_W-1:0] out_fpos_reg, out_ffrom_reg, out_fto_reg;
    logic signed [esc_pkg::COORD_W-1:0] out_spos_reg, out_sfrom_reg, out_sto_reg;
    logic                               out_last_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    logic signed [DW-1:0]               d_up;
    logic signed [DW-1:0]               d_dn;
    logic signed [DW-1:0]               ms_ext;
    logic                               in_range;
    logic                               brk;
    logic                               viol_up;
    logic                               viol_dn;

    assign full = (count_reg == CW'(EDGE_DEPTH));

    always_comb begin
        if (cmd.start) begin
            addr_sel = '0;
        end else if (cmd.advance) begin
            addr_sel = idx_reg + CW'(1);
        end else begin
            addr_sel = idx_reg;
        end
    end

    // edge store
    always_ff @(posedge aclk) begin
        if (cmd.append && !full) begin
            mem_pos[count_reg[AW-1:0]]  <= s_edge_position;
            mem_from[count_reg[AW-1:0]] <= s_span_from;
            mem_to[count_reg[AW-1:0]]   <= s_span_to;
        end
        rd_pos_reg  <= mem_pos[addr_sel[AW-1:0]];
        rd_from_reg <= mem_from[addr_sel[AW-1:0]];
        rd_to_reg   <= mem_to[addr_sel[AW-1:0]];
    end

    // pair test against the stored edge at idx_reg
    always_comb begin
        ms_ext   = $signed({2'b00, ms_reg});
        d_up     = $signed({rd_pos_reg[esc_pkg::COORD_W-1], rd_pos_reg})
                 - $signed({chk_pos_reg[esc_pkg::COORD_W-1], chk_pos_reg});
        d_dn     = $signed({chk_pos_reg[esc_pkg::COORD_W-1], chk_pos_reg})
                 - $signed({rd_pos_reg[esc_pkg::COORD_W-1], rd_pos_reg});
        in_range = (idx_reg < count_reg);
        brk      = (d_up > ms_ext);
        viol_up  = (chk_from_reg < chk_to_reg) && (rd_from_reg > rd_to_reg)
                && (d_up < ms_ext) && (chk_from_reg < rd_from_reg)
                && (rd_to_reg < chk_to_reg);
        viol_dn  = (rd_from_reg < rd_to_reg) && (chk_from_reg > chk_to_reg)
                && (d_dn < ms_ext) && (rd_from_reg < chk_from_reg)
                && (chk_to_reg < rd_to_reg);
        sts.hit        = in_range && ((chk_pos_reg < rd_pos_reg) ? viol_up : viol_dn);
        sts.done       = !in_range || brk;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = !out_valid_reg || m_ready;
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg         <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ms_reg <= cfg_wr_data;
            end
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.append && !full) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.start) begin
                idx_reg <= '0;
            end else if (cmd.advance) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.advance && sts.hit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.emit_last) begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: check edge, pending violation, result register
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            chk_pos_reg  <= s_edge_position;
            chk_from_reg <= s_span_from;
            chk_to_reg   <= s_span_to;
        end
        if (cmd.advance && sts.hit) begin
            pend_pos_reg  <= rd_pos_reg;
            pend_from_reg <= rd_from_reg;
            pend_to_reg   <= rd_to_reg;
        end
        if (cmd.emit) begin
            out_fpos_reg  <= chk_pos_reg;
            out_ffrom_reg <= chk_from_reg;
            out_fto_reg   <= chk_to_reg;
            out_spos_reg  <= pend_pos_reg;
            out_sfrom_reg <= pend_from_reg;
            out_sto_reg   <= pend_to_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_first_position  = out_fpos_reg;
    assign m_first_from      = out_ffrom_reg;
    assign m_first_to        = out_fto_reg;
    assign m_second_position = out_spos_reg;
    assign m_second_from     = out_sfrom_reg;
    assign m_second_to       = out_sto_reg;
    assign m_last_of_run     = out_last_reg;

    `ESC_ASSERT_IMPLY(a_emit_has_pending, aclk, aresetn, cmd.emit, pend_valid_reg)
    `ESC_ASSERT_IMPLY(a_emit_has_room, aclk, aresetn, cmd.emit, !out_valid_reg || m_ready)
    `ESC_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(EDGE_DEPTH))

endmodule

/* rtl/edge_spacing_check_core.sv */
// Edge spacing check core: one edge store of EDGE_DEPTH entries, checked
// edge by edge. Each check walks the store one entry per cycle, holding
// while a found violation waits on the consumer, through the single read
// port of the store, from the first entry up to the first edge past the
// spacing window or the fill count, then hands out the last violation.
// Results for a violating pair come out one per transfer, the final one of
// a check marked by m_last_of_run. The user must write min_spacing through
// cfg_wr_en/cfg_wr_data only while no check is in progress; the block
// does not enforce this.
`timescale 1ns / 1ps

module edge_spacing_check_core #(
    parameter int EDGE_DEPTH = esc_pkg::EDGE_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [esc_pkg::SPACING_W-1:0]        cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [esc_pkg::CMD_W-1:0]            s_command,
    input  logic signed [esc_pkg::COORD_W-1:0]   s_edge_position,
    input  logic signed [esc_pkg::COORD_W-1:0]   s_span_from,
    input  logic signed [esc_pkg::COORD_W-1:0]   s_span_to,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [esc_pkg::COORD_W-1:0]   m_first_position,
    output logic signed [esc_pkg::COORD_W-1:0]   m_first_from,
    output logic signed [esc_pkg::COORD_W-1:0]   m_first_to,
    output logic signed [esc_pkg::COORD_W-1:0]   m_second_position,
    output logic signed [esc_pkg::COORD_W-1:0]   m_second_from,
    output logic signed [esc_pkg::COORD_W-1:0]   m_second_to,
    output logic                                 m_last_of_run
);

    esc_pkg::dp_cmd_t cmd;
    esc_pkg::dp_sts_t sts;

    esc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .sts       (sts),
        .cmd       (cmd)
    );

    esc_dpath #(
        .EDGE_DEPTH (EDGE_DEPTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_edge_position   (s_edge_position),
        .s_span_from       (s_span_from),
        .s_span_to         (s_span_to),
        .cmd               (cmd),
        .sts               (sts),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_first_position  (m_first_position),
        .m_first_from      (m_first_from),
        .m_first_to        (m_first_to),
        .m_second_position (m_second_position),
        .m_second_from     (m_second_from),
        .m_second_to       (m_second_to),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

/* tb/tb_edge_spacing_check_core.sv */
// Self-checking testbench for edge_spacing_check_core: empty store, directed rule cases,
// coordinate extremes, a full store and random check scenes, compared against an in-bench predictor.
// Depends on esc_pkg and the edge_spacing_check_core RTL only.
`timescale 1ns / 1ps

module tb_edge_spacing_check_core;

    localparam int EDGE_DEPTH = esc_pkg::EDGE_DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = EDGE_DEPTH + 16;
    localparam int PHASE_ITEMS = 12;
    localparam logic [esc_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam logic signed [esc_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [esc_pkg::COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic [esc_pkg::SPACING_W-1:0] SPACING_MAX = '1;

    typedef struct packed {
        logic signed [esc_pkg::COORD_W-1:0] first_position;
        logic signed [esc_pkg::COORD_W-1:0] first_from;
        logic signed [esc_pkg::COORD_W-1:0] first_to;
        logic signed [esc_pkg::COORD_W-1:0] second_position;
        logic signed [esc_pkg::COORD_W-1:0] second_from;
        logic signed [esc_pkg::COORD_W-1:0] second_to;
        logic                               last_of_run;
    } violation_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [esc_pkg::SPACING_W-1:0]        cfg_wr_data = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [esc_pkg::CMD_W-1:0]            s_command = esc_pkg::CMD_CLEAR;
    logic signed [esc_pkg::COORD_W-1:0]   s_edge_position = '0;
    logic signed [esc_pkg::COORD_W-1:0]   s_span_from = '0;
    logic signed [esc_pkg::COORD_W-1:0]   s_span_to = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [esc_pkg::COORD_W-1:0]   m_first_position;
    logic signed [esc_pkg::COORD_W-1:0]   m_first_from;
    logic signed [esc_pkg::COORD_W-1:0]   m_first_to;
    logic signed [esc_pkg::COORD_W-1:0]   m_second_position;
    logic signed [esc_pkg::COORD_W-1:0]   m_second_from;
    logic signed [esc_pkg::COORD_W-1:0]   m_second_to;
    logic                                 m_last_of_run;

    logic signed [esc_pkg::COORD_W-1:0]   edge_pos_mem [EDGE_DEPTH];
    logic signed [esc_pkg::COORD_W-1:0]   edge_from_mem [EDGE_DEPTH];
    logic signed [esc_pkg::COORD_W-1:0]   edge_to_mem [EDGE_DEPTH];
    int                                   edge_fill = 0;
    logic [esc_pkg::SPACING_W-1:0]        spacing_now = '0;
    violation_t                           violations_due [$];
    bit                                   failed = 1'b0;
    int                                   items_taken = 0;
    int                                   burst_left = 1;
    logic [15:0]                          ready_pattern = 16'hffff;
    int unsigned                          ready_tick = 0;

    edge_spacing_check_core #(
        .EDGE_DEPTH(EDGE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_edge_position(s_edge_position),
        .s_span_from(s_span_from),
        .s_span_to(s_span_to),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_first_position(m_first_position),
        .m_first_from(m_first_from),
        .m_first_to(m_first_to),
        .m_second_position(m_second_position),
        .m_second_from(m_second_from),
        .m_second_to(m_second_to),
        .m_last_of_run(m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // Apply one accepted item to the edge store; queue the violations it causes.
    // Returns 0 when the block ignores the item.
    function automatic bit apply_edge(input logic [esc_pkg::CMD_W-1:0] cmd,
                                      input logic signed [esc_pkg::COORD_W-1:0] pos,
                                      input logic signed [esc_pkg::COORD_W-1:0] span_a,
                                      input logic signed [esc_pkg::COORD_W-1:0] span_b);
        longint p1, f1, t1, p2, f2, t2, thr;
        violation_t held;
        bit have_held, hit;
        int i;
        have_held = 1'b0;
        p1 = pos;
        f1 = span_a;
        t1 = span_b;
        thr = {33'd0, spacing_now};
        case (cmd)
            esc_pkg::CMD_CLEAR: begin
                edge_fill = 0;
                return 1'b1;
            end
            esc_pkg::CMD_APPEND: begin
                if (edge_fill == EDGE_DEPTH)
                    return 1'b0;
                edge_pos_mem[edge_fill] = pos;
                edge_from_mem[edge_fill] = span_a;
                edge_to_mem[edge_fill] = span_b;
                edge_fill++;
                return 1'b1;
            end
            esc_pkg::CMD_CHECK: begin
                for (i = 0; i < edge_fill; i++) begin
                    p2 = edge_pos_mem[i];
                    f2 = edge_from_mem[i];
                    t2 = edge_to_mem[i];
                    if (p2 < p1 - thr)
                        continue;
                    if (p2 > p1 + thr)
                        break;
                    if (p1 < p2)
                        hit = f1 < t1 && f2 > t2 && p2 - p1 < thr && f1 < f2 && t2 < t1;
                    else
                        hit = f2 < t2 && f1 > t1 && p1 - p2 < thr && f2 < f1 && t1 < t2;
                    if (hit) begin
                        if (have_held)
                            violations_due.push_back(held);
                        held.first_position = pos;
                        held.first_from = span_a;
                        held.first_to = span_b;
                        held.second_position = edge_pos_mem[i];
                        held.second_from = edge_from_mem[i];
                        held.second_to = edge_to_mem[i];
                        held.last_of_run = 1'b0;
                        have_held = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last_of_run = 1'b1;
                    violations_due.push_back(held);
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%h, actual 0x%h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin : check_violations
        violation_t want;
        if (aresetn && m_valid && m_ready) begin
            if (violations_due.size() == 0) begin
                $error("violation transfer with none expected at %0t", $realtime);
                failed = 1'b1;
            end else begin
                want = violations_due.pop_front();
                compare_field("first_position", want.first_position, m_first_position);
                compare_field("first_from", want.first_from, m_first_from);
                compare_field("first_to", want.first_to, m_first_to);
                compare_field("second_position", want.second_position, m_second_position);
                compare_field("second_from", want.second_from, m_second_from);
                compare_field("second_to", want.second_to, m_second_to);
                compare_field("last_of_run", {31'd0, want.last_of_run}, {31'd0, m_last_of_run});
            end
        end
    end

    always @(posedge aclk) begin
        if (ready_tick % 128 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hffff;
                1: ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
                default: ready_pattern = 16'($urandom) | 16'h0001;
            endcase
        end
        m_ready <= ready_pattern[ready_tick % 16];
        ready_tick++;
    end

    task automatic send_edge(input logic [esc_pkg::CMD_W-1:0] cmd,
                             input logic signed [esc_pkg::COORD_W-1:0] pos,
                             input logic signed [esc_pkg::COORD_W-1:0] span_a,
                             input logic signed [esc_pkg::COORD_W-1:0] span_b);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_edge_position <= pos;
        s_span_from <= span_a;
        s_span_to <= span_b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (apply_edge(cmd, pos, span_a, span_b))
            items_taken++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic pause_input();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        pause_input();
        while (violations_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_spacing(input logic [esc_pkg::SPACING_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        spacing_now = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Edge with a random span of up to 64 near span_base, random direction.
    task automatic send_span_edge(input logic [esc_pkg::CMD_W-1:0] cmd,
                                  input logic signed [esc_pkg::COORD_W-1:0] pos,
                                  input int span_base);
        int a, b;
        a = span_base + $urandom_range(0, 64);
        b = span_base + $urandom_range(0, 64);
        if ((a < b) ^ ($urandom_range(0, 1) == 1))
            send_edge(cmd, pos, a, b);
        else
            send_edge(cmd, pos, b, a);
    endtask

    task automatic test_empty_store();
        send_edge(esc_pkg::CMD_CHECK, 0, 0, 10);
        send_edge(CMD_UNKNOWN, 32'sh1234_5678, -1, 1);
        send_edge(esc_pkg::CMD_APPEND, 0, 0, 10);
        send_edge(esc_pkg::CMD_CHECK, 0, 10, 0);
        send_edge(esc_pkg::CMD_CLEAR, 0, 0, 0);
        pause_input();
    endtask

    task automatic test_rule_cases();
        write_spacing(31'd10);
        send_edge(esc_pkg::CMD_CLEAR, 0, 0, 0);
        send_edge(esc_pkg::CMD_APPEND, 100, 0, 50);
        send_edge(esc_pkg::CMD_APPEND, 105, 40, 10);
        send_edge(esc_pkg::CMD_APPEND, 112, 45, 5);
        send_edge(esc_pkg::CMD_APPEND, 130, 0, 60);
        send_edge(esc_pkg::CMD_APPEND, 90, 0, 60);
        send_edge(esc_pkg::CMD_CHECK, 102, 5, 45);
        send_edge(esc_pkg::CMD_CHECK, 105, 45, 5);
        send_edge(esc_pkg::CMD_CHECK, 110, 50, 0);
        send_edge(esc_pkg::CMD_CHECK, 100, 30, 20);
        send_edge(esc_pkg::CMD_CHECK, 103, 0, -20);
        send_edge(esc_pkg::CMD_CHECK, 95, 45, 5);
        send_edge(esc_pkg::CMD_CHECK, 122, 70, 1);
        send_edge(CMD_UNKNOWN, 100, 30, 20);
        pause_input();
    endtask

    task automatic test_coordinate_extremes();
        write_spacing(SPACING_MAX);
        send_edge(esc_pkg::CMD_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX);
        send_edge(esc_pkg::CMD_APPEND, COORD_MIN, COORD_MIN, COORD_MAX);
        send_edge(esc_pkg::CMD_APPEND, COORD_MIN + 2, COORD_MAX, COORD_MIN);
        send_edge(esc_pkg::CMD_APPEND, COORD_MAX, -100, 100);
        send_edge(esc_pkg::CMD_CHECK, COORD_MIN + 3, 5, -5);
        send_edge(esc_pkg::CMD_CHECK, COORD_MAX, 50, -50);
        send_edge(esc_pkg::CMD_CHECK, COORD_MIN, COORD_MIN, COORD_MAX);
        pause_input();
    endtask

    task automatic test_full_store();
        logic signed [esc_pkg::COORD_W-1:0] base;
        int span_base, i;
        write_spacing(31'd300);
        base = $urandom_range(0, 32'h3fff_ffff);
        if ($urandom_range(0, 1) == 1)
            base = -base;
        span_base = $urandom_range(0, 32'h3fff_ffff);
        send_edge(esc_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
        for (i = 0; i < EDGE_DEPTH + 2; i++)
            send_edge(esc_pkg::CMD_APPEND, base + i, span_base + $urandom_range(0, 10),
                      span_base + 90 + $urandom_range(0, 10));
        send_edge(esc_pkg::CMD_CHECK, base + EDGE_DEPTH - 1, span_base + 60,
                  span_base + 40);
        send_span_edge(esc_pkg::CMD_CHECK, base + $urandom_range(0, EDGE_DEPTH), span_base);
        pause_input();
    endtask

    // Clear, fill a small store mostly in position order, then check edges around it.
    task automatic run_scene();
        logic signed [esc_pkg::COORD_W-1:0] base;
        int n_store, n_check, w, off, span_base, k;
        bit unsorted;
        n_store = $urandom_range(0, 10);
        n_check = $urandom_range(1, 4);
        w = (spacing_now > 400) ? 400 : int'(spacing_now) + 2;
        case ($urandom_range(0, 3))
            0: base = COORD_MIN + $urandom_range(0, 200);
            1: base = COORD_MAX - $urandom_range(4000, 5000);
            default: base = $urandom;
        endcase
        unsorted = ($urandom_range(0, 7) == 0);
        span_base = $urandom;
        send_edge(esc_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
        off = 0;
        for (k = 0; k < n_store; k++) begin
            off = unsorted ? $urandom_range(0, 4 * w) : off + $urandom_range(0, w / 2);
            send_span_edge(esc_pkg::CMD_APPEND, base + off, span_base);
        end
        for (k = 0; k < n_check; k++)
            send_span_edge(esc_pkg::CMD_CHECK, base + $urandom_range(0, off + 2 * w) - w,
                           span_base);
    endtask

    task automatic test_random_scenes(input logic [31:0] spacing);
        int start;
        logic [31:0] pick;
        write_spacing(spacing[esc_pkg::SPACING_W-1:0]);
        start = items_taken;
        while (items_taken - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 3);
                send_edge(pick[esc_pkg::CMD_W-1:0], $urandom, $urandom, $urandom);
            end
            run_scene();
        end
        pause_input();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_store();
        test_rule_cases();
        test_coordinate_extremes();
        test_full_store();
        test_random_scenes(32'd1);
        test_random_scenes(32'd300);
        test_random_scenes($urandom_range(2, 2000));
        test_random_scenes($urandom & 32'h7fff_ffff);
        test_random_scenes({1'b0, SPACING_MAX});
        test_random_scenes(32'd0);
        drain_results();
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
